>>> rtl/core/swmf_pkg.sv
package swmf_pkg;

  localparam int WINDOW_SIZE = 8;
  localparam int AGE_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int MID_HI      = WINDOW_SIZE / 2;
  localparam int MID_LO      = (WINDOW_SIZE > 1) ? (WINDOW_SIZE / 2 - 1) : 0;
  localparam bit WIN_EVEN    = (WINDOW_SIZE % 2) == 0;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WINDOW_SIZE - 1);

  typedef logic signed [31:0] sample_t;
  typedef logic [AGE_W-1:0]   age_t;

  // one window entry as it travels between neighbor cells
  typedef struct packed {
    sample_t val;
    age_t    age;
  } entry_t;

endpackage

>>> rtl/core/swmf_cell.sv
module swmf_cell
  import swmf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  logic    is_last,
  input  age_t    init_age,
  input  sample_t new_sample,
  input  logic    gone_in,
  input  entry_t  right_entry,
  input  entry_t  left_comp,
  input  logic    left_gt,
  output logic    gone_out,
  output entry_t  comp,
  output logic    comp_gt,
  output entry_t  entry,
  output logic    is_oldest
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   le;

  assign is_oldest = (entry_r.age == AGE_MAX);
  assign gone_out  = gone_in | is_oldest;

  // window with the oldest entry squeezed out
  assign comp    = gone_out ? right_entry : entry_r;
  assign comp_gt = comp.val > new_sample;
  assign le      = !is_last && !comp_gt;

  always_comb begin
    priority if (le) begin
      entry_nxt.val = comp.val;
      entry_nxt.age = comp.age + 1'b1;
    end else if (left_gt) begin
      entry_nxt.val = left_comp.val;
      entry_nxt.age = left_comp.age + 1'b1;
    end else begin
      entry_nxt.val = new_sample;
      entry_nxt.age = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.val <= '0;
      entry_r.age <= init_age;
    end else if (load) begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

>>> rtl/core/sliding_window_median_filter_unit.sv
// Running median over the last WINDOW_SIZE signed 32-bit samples, window all zero after
// reset. The window is held sorted in a row of cells; each cell knows its entry's age, so a
// new word drops the oldest entry and slides into place as it is accepted. The median (middle
// entry, or the mean of the middle pair truncated toward zero) is then loaded into the output
// register once it is free, and new words stall while it is pending. A result waiting in the
// output register does not block the next insert.
module sliding_window_median_filter_unit
  import swmf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t in_sample,
  output logic    out_valid,
  input  logic    out_stall,
  output sample_t out_median_value
);

  logic   accept;
  logic   pend_r;
  logic   out_valid_r;
  logic   out_free;
  sample_t median_r;
  sample_t median_nxt;

  logic   gone  [WINDOW_SIZE+1];
  logic   gt    [WINDOW_SIZE+1];
  entry_t comps [WINDOW_SIZE+1];
  entry_t ents  [WINDOW_SIZE+1];
  logic [WINDOW_SIZE-1:0] oldest;

  assign out_free = !out_valid_r || !out_stall;
  // the window holds a pending median until the output register frees up
  assign in_stall = pend_r;
  assign accept   = in_valid && !in_stall;

  assign gone[0]           = 1'b0;
  assign gt[0]             = 1'b0;
  assign comps[0]          = '0;
  assign ents[WINDOW_SIZE] = '0;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    swmf_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .load        (accept),
      .is_last     (i == WINDOW_SIZE - 1),
      .init_age    (AGE_W'(i)),
      .new_sample  (in_sample),
      .gone_in     (gone[i]),
      .right_entry (ents[i+1]),
      .left_comp   (comps[i]),
      .left_gt     (gt[i]),
      .gone_out    (gone[i+1]),
      .comp        (comps[i+1]),
      .comp_gt     (gt[i+1]),
      .entry       (ents[i]),
      .is_oldest   (oldest[i])
    );
  end

  if (WIN_EVEN) begin : g_even
    logic signed [32:0] pair_sum;
    logic signed [32:0] pair_adj;
    assign pair_sum   = 33'(ents[MID_LO].val) + 33'(ents[MID_HI].val);
    // round toward zero for negative sums
    assign pair_adj   = pair_sum + {32'd0, pair_sum[32]};
    assign median_nxt = pair_adj[32:1];
  end else begin : g_odd
    assign median_nxt = ents[MID_HI].val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pend_r <= 1'b1;
      end else if (pend_r && out_free) begin
        pend_r <= 1'b0;
      end
      if (pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      median_r <= median_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = median_r;

`ifndef SYNTHESIS
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(oldest) == 1)
    else $error("window must hold exactly one oldest entry");

  a_pend_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> pend_r && !accept)
    else $error("accepted word not pending for output");

  a_mid_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    ents[MID_LO].val <= ents[MID_HI].val)
    else $error("middle entries out of order");
`endif

endmodule
